>>> rtl/chc_pkg.sv
// Shared constants, register indexes and the CORDIC arctangent table
// for the hard-iron calibrating compass. No dependencies.
package chc_pkg;

  // Angles are degrees in signed Q.16
  localparam int Q_BITS    = 16;
  localparam int ANGLE_W   = 28;
  localparam int ATAN_W    = 22;
  localparam int TAB_IDX_W = 5;
  localparam int HEADING_W = 9;

  localparam logic signed [ANGLE_W-1:0] HALF_TURN = 28'sd11796480;
  localparam logic signed [ANGLE_W-1:0] FULL_TURN = 28'sd23592960;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DECL_DEG_W = 8;
  localparam int DECL_MIN_W = 7;
  localparam int COUNT_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DECL_DEG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECL_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 2'd2;

  localparam logic [COUNT_W-1:0] SETTLE_RESET = 16'd200;

  // atan(2^-i) in Q.16 degrees, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/compass_hard_iron_calibration_heading_top.sv
// Top level of the hard-iron calibrating compass: sequencer, calibration
// tracking, declination and heading wrap. Depends on chc_pkg, chc_cordic.
//
// Each X/Y sample transfer yields exactly one result transfer. Until
// calibration ends the block widens per-axis min/max bounds (starting at
// zero), reports the centers (max+min)/2 truncated toward zero as offsets,
// and counts samples whose centers did not move; the count is cumulative
// and calibration ends on the sample where it equals settle_count (that
// sample carries no heading). Afterwards each sample is offset-corrected
// and run through an iterative CORDIC atan2, one rotation per clock, then
// declination (degrees + minutes/60) is added and the sum wrapped once
// into 0..360 and floored to whole degrees. A calibration sample passes
// through S_CAL and S_OUT to the output register; a heading sample through
// S_CORR, the CORDIC loop in S_ANG, then S_WRAP, S_FIN and S_OUT, and the
// loop is skipped when the corrected vector is zero.
// One sample is in work at a time; a finished result sits in the output
// register so the next sample can be taken while it waits. Configuration
// is a plain write port: 0 declination degrees, 1 declination minutes,
// 2 settle count; other indexes are ignored.
module compass_hard_iron_calibration_heading_top #(
  parameter int CORDIC_STEPS = 16,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_we,
  input  logic [chc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [chc_pkg::CFG_DATA_W-1:0]     cfg_data,
  // sample channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SAMPLE_BITS-1:0]      mag_x,
  input  logic signed [SAMPLE_BITS-1:0]      mag_y,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               calibrated,
  output logic                               heading_valid,
  output logic [chc_pkg::HEADING_W-1:0]      heading_degrees,
  output logic signed [SAMPLE_BITS-1:0]      offset_x,
  output logic signed [SAMPLE_BITS-1:0]      offset_y
);
  import chc_pkg::*;

  localparam int S = SAMPLE_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_CAL, S_CORR, S_ANG, S_WRAP, S_FIN, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic signed [DECL_DEG_W-1:0] decl_deg;
  logic signed [DECL_MIN_W-1:0] decl_min;
  logic [COUNT_W-1:0]           settle_count;
  logic signed [ANGLE_W-1:0]    decl;

  // calibration state
  logic signed [S-1:0] min_x, max_x, min_y, max_y;
  logic signed [S-1:0] center_x, center_y;
  logic [COUNT_W-1:0]  unchanged_count;
  logic                done_flag;

  // sample and work registers
  logic signed [S-1:0]       sx, sy;
  logic signed [ANGLE_W-1:0] hsum;

  // pending result
  logic                      res_cal, res_valid;
  logic [HEADING_W-1:0]      res_heading;
  logic signed [S-1:0]       res_off_x, res_off_y;

  logic in_xfer, out_free;
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // declination in Q.16: minutes*65536/60 = m*1092 + floor(4m/15),
  // the small quotient by reciprocal multiply (exact for |m| <= 64)
  logic [DECL_MIN_W:0]       min_abs;
  logic [17:0]               frac_mag;
  logic signed [ANGLE_W-1:0] frac, deg_term, decl_next;
  always_comb begin
    min_abs   = decl_min[DECL_MIN_W-1] ? (DECL_MIN_W+1)'(-(DECL_MIN_W+1)'(decl_min))
                                       : (DECL_MIN_W+1)'(decl_min);
    frac_mag  = 18'(min_abs) * 18'd1092 + ((18'(min_abs) * 18'd1096) >> 12);
    frac      = decl_min[DECL_MIN_W-1] ? -ANGLE_W'(frac_mag) : ANGLE_W'(frac_mag);
    deg_term  = ANGLE_W'(decl_deg) <<< Q_BITS;
    decl_next = deg_term + frac;
  end

  // calibration update for the held sample
  logic signed [S-1:0] nmin_x, nmax_x, nmin_y, nmax_y, cx, cy;
  logic signed [S:0]   sum_x, sum_y, half_x, half_y;
  logic [COUNT_W-1:0]  count_next;
  always_comb begin
    nmin_x = (sx < min_x) ? sx : min_x;
    nmax_x = (sx > max_x) ? sx : max_x;
    nmin_y = (sy < min_y) ? sy : min_y;
    nmax_y = (sy > max_y) ? sy : max_y;
    sum_x  = (S+1)'(nmax_x) + (S+1)'(nmin_x);
    sum_y  = (S+1)'(nmax_y) + (S+1)'(nmin_y);
    // bias negatives by one so the halving truncates toward zero
    half_x = (sum_x + {{S{1'b0}}, sum_x[S]}) >>> 1;
    half_y = (sum_y + {{S{1'b0}}, sum_y[S]}) >>> 1;
    cx     = half_x[S-1:0];
    cy     = half_y[S-1:0];
    count_next = (cx == center_x && cy == center_y) ? unchanged_count + 1'b1
                                                    : unchanged_count;
  end

  // corrected vector into the CORDIC
  logic signed [S:0]         dx, dy;
  logic                      cordic_done;
  logic signed [ANGLE_W-1:0] cordic_angle;
  assign dx = (S+1)'(sx) - (S+1)'(center_x);
  assign dy = (S+1)'(sy) - (S+1)'(center_y);

  chc_cordic #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_CORR),
    .x_in  (dx),
    .y_in  (dy),
    .done  (cordic_done),
    .angle (cordic_angle)
  );

  // upper wrap and clamp of negatives to zero, then floor to whole degrees
  logic signed [ANGLE_W-1:0] h_hi;
  always_comb begin
    h_hi = (hsum > FULL_TURN) ? hsum - FULL_TURN : hsum;
    if (h_hi[ANGLE_W-1]) begin
      h_hi = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      decl_deg        <= '0;
      decl_min        <= '0;
      settle_count    <= SETTLE_RESET;
      decl            <= '0;
      min_x           <= '0;
      max_x           <= '0;
      min_y           <= '0;
      max_y           <= '0;
      center_x        <= '0;
      center_y        <= '0;
      unchanged_count <= '0;
      done_flag       <= 1'b0;
    end else begin
      decl <= decl_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_DECL_DEG: decl_deg     <= cfg_data[DECL_DEG_W-1:0];
          REG_DECL_MIN: decl_min     <= cfg_data[DECL_MIN_W-1:0];
          REG_SETTLE:   settle_count <= cfg_data[COUNT_W-1:0];
          default:      ;
        endcase
      end

      // S_OUT reloads the output register itself when it frees up
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            sx    <= mag_x;
            sy    <= mag_y;
            state <= done_flag ? S_CORR : S_CAL;
          end
        end
        S_CAL: begin
          min_x           <= nmin_x;
          max_x           <= nmax_x;
          min_y           <= nmin_y;
          max_y           <= nmax_y;
          center_x        <= cx;
          center_y        <= cy;
          unchanged_count <= count_next;
          done_flag       <= (count_next == settle_count);
          res_cal         <= (count_next == settle_count);
          res_valid       <= 1'b0;
          res_heading     <= '0;
          res_off_x       <= cx;
          res_off_y       <= cy;
          state           <= S_OUT;
        end
        S_CORR: begin
          state <= S_ANG;
        end
        S_ANG: begin
          if (cordic_done) begin
            hsum  <= cordic_angle + decl;
            state <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (hsum[ANGLE_W-1]) begin
            hsum <= hsum + FULL_TURN;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          res_cal     <= 1'b1;
          res_valid   <= 1'b1;
          res_heading <= h_hi[Q_BITS+HEADING_W-1:Q_BITS];
          res_off_x   <= center_x;
          res_off_y   <= center_y;
          state       <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            calibrated      <= res_cal;
            heading_valid   <= res_valid;
            heading_degrees <= res_heading;
            offset_x        <= res_off_x;
            offset_y        <= res_off_y;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/chc_cordic.sv
// Iterative vectoring CORDIC atan2, one rotation per clock.
// Depends on chc_pkg for the angle format and arctangent table.
module chc_cordic #(
  parameter int SAMPLE_BITS  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [SAMPLE_BITS:0]          x_in,
  input  logic signed [SAMPLE_BITS:0]          y_in,
  output logic                                 done,
  output logic signed [chc_pkg::ANGLE_W-1:0]   angle
);
  import chc_pkg::*;

  // mirrored input needs one more bit, x256 pre-scale, gain and sqrt2 margin
  localparam int W      = SAMPLE_BITS + 12;
  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  logic                     running;
  logic [STEP_W-1:0]        step;
  logic signed [W-1:0]      x;
  logic signed [W-1:0]      y;

  logic signed [SAMPLE_BITS+1:0] xe, ye, xm, ym;
  logic signed [W-1:0]           xs, ys;
  logic signed [ANGLE_W-1:0]     step_angle;
  logic                          rot_neg;

  assign xe = (SAMPLE_BITS+2)'(x_in);
  assign ye = (SAMPLE_BITS+2)'(y_in);
  // left half plane is mirrored through the origin
  assign xm = xe[SAMPLE_BITS+1] ? -xe : xe;
  assign ym = xe[SAMPLE_BITS+1] ? -ye : ye;

  assign xs         = x >>> step;
  assign ys         = y >>> step;
  assign step_angle = ANGLE_W'({1'b0, atan_entry(TAB_IDX_W'(step))});
  assign rot_neg    = y[W-1] || (y == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= '0;
        x    <= W'(xm) <<< 8;
        y    <= W'(ym) <<< 8;
        if (x_in == '0 && y_in == '0) begin
          angle <= '0;
          done  <= 1'b1;
        end else begin
          running <= 1'b1;
          if (xe[SAMPLE_BITS+1]) begin
            angle <= ye[SAMPLE_BITS+1] ? -HALF_TURN : HALF_TURN;
          end else begin
            angle <= '0;
          end
        end
      end else if (running) begin
        if (rot_neg) begin
          x     <= x - ys;
          y     <= y + xs;
          angle <= angle - step_angle;
        end else begin
          x     <= x + ys;
          y     <= y - xs;
          angle <= angle + step_angle;
        end
        if (step == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

endmodule

>>> bench/tb_compass_hard_iron_calibration_heading_top.sv
// Self-checking bench for compass_hard_iron_calibration_heading_top: a queued
// sample driver, a result monitor and a built-in calibration/CORDIC predictor.
// Depends on chc_pkg and the compass top level only.
module tb_compass_hard_iron_calibration_heading_top;
  import chc_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int SAMPLE_BITS  = 16;

  // Angles in Q.16 degrees
  localparam longint DEG_Q16       = 65536;
  localparam longint HALF_TURN_Q16 = 180 * DEG_Q16;
  localparam longint FULL_TURN_Q16 = 360 * DEG_Q16;

  // Index past the register list; writes there must do nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
  } mag_sample_t;

  typedef struct packed {
    logic                          calibrated;
    logic                          heading_valid;
    logic [HEADING_W-1:0]          heading;
    logic signed [SAMPLE_BITS-1:0] offset_x;
    logic signed [SAMPLE_BITS-1:0] offset_y;
  } compass_result_t;

  // Stimulus side, every input known from time zero
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic signed [SAMPLE_BITS-1:0] mag_x = '0;
  logic signed [SAMPLE_BITS-1:0] mag_y = '0;
  logic                          out_stall = 1'b0;

  logic                          in_stall;
  logic                          out_valid;
  logic                          calibrated;
  logic                          heading_valid;
  logic [HEADING_W-1:0]          heading_degrees;
  logic signed [SAMPLE_BITS-1:0] offset_x;
  logic signed [SAMPLE_BITS-1:0] offset_y;

  mag_sample_t     mag_samples_queued[$];
  compass_result_t compass_results_due[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit in_taken       = 1'b0;
  int mismatches     = 0;

  // Predictor state: calibration bounds, centers, counter and register copies
  longint      lo_x = 0, hi_x = 0, lo_y = 0, hi_y = 0;
  longint      ctr_x = 0, ctr_y = 0, last_ctr_x = 0, last_ctr_y = 0;
  logic [15:0] still_count = '0;
  bit          cal_done = 1'b0;
  int          decl_deg = 0;
  int          decl_min = 0;
  logic [15:0] settle_target = 16'd200;

  // atan(2^-i) in Q.16 degrees
  longint atan_deg_q16 [0:15] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  compass_hard_iron_calibration_heading_top #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mag_x           (mag_x),
    .mag_y           (mag_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .calibrated      (calibrated),
    .heading_valid   (heading_valid),
    .heading_degrees (heading_degrees),
    .offset_x        (offset_x),
    .offset_y        (offset_y)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Vectoring CORDIC: inputs scaled by 256, shifts floor toward minus infinity
  function automatic longint cordic_angle(input longint ey, input longint ex);
    longint xr, yr, xs, ys, z;
    if (ex == 0 && ey == 0) return 0;
    z  = 0;
    xr = ex;
    yr = ey;
    // left half plane: mirror and start from +/-180
    if (ex < 0) begin
      z  = (ey >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
      xr = -ex;
      yr = -ey;
    end
    xr = xr * 256;
    yr = yr * 256;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = xr >>> i;
      ys = yr >>> i;
      if (yr > 0) begin
        xr = xr + ys;
        yr = yr - xs;
        z  = z + atan_deg_q16[i];
      end else begin
        xr = xr - ys;
        yr = yr + xs;
        z  = z - atan_deg_q16[i];
      end
    end
    return z;
  endfunction

  // One sample through the compass: calibration update or heading
  function automatic compass_result_t compass_step(input logic signed [SAMPLE_BITS-1:0] mx,
                                                   input logic signed [SAMPLE_BITS-1:0] my);
    compass_result_t r;
    longint sx, sy, h;
    sx = mx;
    sy = my;
    r  = '0;
    if (!cal_done) begin
      if (sx < lo_x) lo_x = sx;
      if (sx > hi_x) hi_x = sx;
      if (sy < lo_y) lo_y = sy;
      if (sy > hi_y) hi_y = sy;
      // division truncates toward zero
      ctr_x = (hi_x + lo_x) / 2;
      ctr_y = (hi_y + lo_y) / 2;
      // cumulative, wraps at 16 bits
      if (ctr_x == last_ctr_x && ctr_y == last_ctr_y) still_count = still_count + 16'd1;
      last_ctr_x = ctr_x;
      last_ctr_y = ctr_y;
      if (still_count == settle_target) cal_done = 1'b1;
    end else begin
      h = cordic_angle(sy - ctr_y, sx - ctr_x) + longint'(decl_deg) * DEG_Q16
          + (longint'(decl_min) * DEG_Q16) / 60;
      // single wrap, exactly 360 stays
      if (h < 0) h = h + FULL_TURN_Q16;
      if (h > FULL_TURN_Q16) h = h - FULL_TURN_Q16;
      if (h < 0) h = 0;
      r.heading_valid = 1'b1;
      r.heading       = HEADING_W'(h >>> 16);
    end
    r.calibrated = cal_done;
    r.offset_x   = SAMPLE_BITS'(ctr_x);
    r.offset_y   = SAMPLE_BITS'(ctr_y);
    return r;
  endfunction

  // One line per mismatch, every one counted
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d want %0d", what, got, want);
    mismatches++;
  endtask

  task automatic set_idle(input idle_mode_e m);
    send_idle_pct  = (m == IDLE_SEND) ? 69 : (m == IDLE_BOTH) ? 19 : 0;
    recv_stall_pct = (m == IDLE_RECV) ? 69 : (m == IDLE_BOTH) ? 19 : 0;
  endtask

  task automatic queue_sample(input int x, input int y);
    mag_sample_t s;
    s.x = SAMPLE_BITS'(x);
    s.y = SAMPLE_BITS'(y);
    mag_samples_queued.push_back(s);
  endtask

  // Samples inside the current bounds leave the centers where they are
  task automatic queue_in_bounds(input int n);
    repeat (n) queue_sample(int'(lo_x) + int'($urandom_range(int'(hi_x - lo_x))),
                            int'(lo_y) + int'($urandom_range(int'(hi_y - lo_y))));
  endtask

  // Mix of full-range samples, near-zero corrected vectors and on-axis vectors
  task automatic queue_random_heading();
    int cx, cy;
    cx = int'(ctr_x);
    cy = int'(ctr_y);
    case ($urandom_range(3))
      0: queue_sample(cx + int'($urandom_range(64)) - 32, cy + int'($urandom_range(64)) - 32);
      1: begin
        if ($urandom_range(1) != 0) queue_sample(cx, int'($urandom));
        else queue_sample(int'($urandom), cy);
      end
      default: queue_sample(int'($urandom), int'($urandom));
    endcase
  endtask

  // Register write with random bits above the register width
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    logic [CFG_DATA_W-1:0] keep, data;
    case (idx)
      REG_DECL_DEG: keep = 16'h00FF;
      REG_DECL_MIN: keep = 16'h007F;
      REG_SETTLE:   keep = 16'hFFFF;
      default:      keep = 16'h0000;
    endcase
    data = (CFG_DATA_W'(val) & keep) | (CFG_DATA_W'($urandom) & ~keep);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DECL_DEG: decl_deg = int'($signed(data[7:0]));
      REG_DECL_MIN: decl_min = int'($signed(data[6:0]));
      REG_SETTLE:   settle_target = data;
      default: ;
    endcase
  endtask

  // Block is idle once every queued sample has made its result transfer
  task automatic drain();
    while (mag_samples_queued.size() != 0 || in_valid || compass_results_due.size() != 0)
      @(posedge clk);
  endtask

  // Sample driver: a new payload only after the previous transfer, random gaps
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (mag_samples_queued.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        mag_x    <= mag_samples_queued[0].x;
        mag_y    <= mag_samples_queued[0].y;
        void'(mag_samples_queued.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: check result transfers, predict on sample transfers
  always @(posedge clk) begin
    compass_result_t want;
    in_taken = in_valid && !in_stall && !rst;
    if (!rst && out_valid && !out_stall) begin
      if (compass_results_due.size() == 0) begin
        report_mismatch("result transfer with none due", 1, 0);
      end else begin
        want = compass_results_due.pop_front();
        if (calibrated !== want.calibrated)
          report_mismatch("calibrated", calibrated, want.calibrated);
        if (heading_valid !== want.heading_valid)
          report_mismatch("heading_valid", heading_valid, want.heading_valid);
        if (heading_degrees !== want.heading)
          report_mismatch("heading_degrees", heading_degrees, want.heading);
        if (offset_x !== want.offset_x)
          report_mismatch("offset_x", offset_x, want.offset_x);
        if (offset_y !== want.offset_y)
          report_mismatch("offset_y", offset_y, want.offset_y);
      end
    end
    if (in_taken) compass_results_due.push_back(compass_step(mag_x, mag_y));
  end

  initial begin
    int cx, cy;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Calibration at reset settings: zero start, one axis pinned at each
    // extreme, odd negative sum for the truncating center
    set_idle(IDLE_BOTH);
    queue_sample(0, 0);
    queue_sample(5, -3);
    queue_sample(5, -3);
    queue_sample(-32768, 32767);
    queue_sample(-1, 0);
    queue_sample(-32768, 32767);
    queue_sample(5, -3);
    drain();

    // settle_count 300 past the present count: in-bounds samples keep the
    // centers still, so the cumulative counter climbs to it over three
    // idle modes and the last of them ends calibration
    write_reg(REG_SETTLE, int'(still_count) + 300);
    queue_in_bounds(100);
    drain();
    set_idle(IDLE_SEND);
    queue_in_bounds(100);
    drain();
    set_idle(IDLE_RECV);
    queue_in_bounds(100);
    drain();
    // first headings at zero declination, no idling
    set_idle(IDLE_NONE);
    repeat (20) queue_random_heading();
    drain();

    // Directed headings: zero vector, left half plane both sides of the axis,
    // axes, extreme raw samples
    cx = int'(ctr_x);
    cy = int'(ctr_y);
    set_idle(IDLE_BOTH);
    write_reg(REG_DECL_DEG, 90);
    write_reg(REG_DECL_MIN, 59);
    queue_sample(cx, cy);
    queue_sample(cx - 1, cy);
    queue_sample(cx - 5, cy - 1);
    queue_sample(cx, cy + 7);
    queue_sample(cx, cy - 7);
    queue_sample(cx + 3, cy);
    queue_sample(-32768, -32768);
    queue_sample(32767, 32767);
    drain();
    // negative declination pushes small angles below zero: wrap case
    write_reg(REG_DECL_DEG, -90);
    write_reg(REG_DECL_MIN, -59);
    queue_sample(cx, cy);
    queue_sample(cx + 1000, cy - 1);
    queue_sample(cx + 1000, cy + 1);
    queue_sample(-32768, 32767);
    queue_sample(32767, -32768);
    queue_sample(cx - 1, cy);
    drain();

    // Random phases: field extremes of the declination first, settle_count
    // writes after calibration, a spare-index write, all idle modes
    for (int p = 0; p < 10; p++) begin
      set_idle(idle_mode_e'(p % 4));
      write_reg(REG_DECL_DEG, (p == 0) ? 127 : (p == 1) ? -128 : int'($urandom_range(255)) - 128);
      write_reg(REG_DECL_MIN, (p == 0) ? 63 : (p == 1) ? -64 : int'($urandom_range(127)) - 64);
      if (p == 2) write_reg(REG_SETTLE, 65535);
      if (p == 5) write_reg(REG_SETTLE, 1);
      if (p == 7) write_reg(REG_SPARE, 0);
      repeat (80) queue_random_heading();
      drain();
    end

    // tail: catch any stray result transfer
    repeat (CORDIC_STEPS + 16) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_compass_hard_iron_calibration_heading_top passed");
    end else begin
      $display("tb_compass_hard_iron_calibration_heading_top failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #1_000_000;
    $display("tb_compass_hard_iron_calibration_heading_top failed");
    $finish;
  end

endmodule
